// ===== rtl/gdate_pkg.sv =====
`timescale 1ns / 1ps
package gdate_pkg;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [13:0] CYCLE_LEN = 14'd400;
  localparam logic [13:0] CENTURY = 14'd100;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_INIT,
    ST_STEP,
    ST_DONE
  } gd_state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_MOD,
    OP_INIT,
    OP_STEP
  } gd_op_t;

  typedef struct packed {
    gd_op_t op;
  } gd_cmd_t;

  typedef struct packed {
    logic mod_ge;
    logic step_more;
    logic step_ovf;
  } gd_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? FEB_LEAP_LEN : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/gdate_dp.sv =====
`timescale 1ns / 1ps
module gdate_dp import gdate_pkg::*; (
  input  logic        clk,
  input  gd_cmd_t     cmd,
  input  logic        in_req_type,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic [15:0] in_day_count,
  output gd_status_t  status,
  output logic [13:0] out_result_year,
  output logic [3:0]  out_result_month,
  output logic [4:0]  out_result_day,
  output logic        out_year_overflow
);

  logic               sub_r, sub_nxt;
  logic [13:0]        y_r, y_nxt;
  logic [3:0]         m_r, m_nxt;
  logic signed [17:0] d_r, d_nxt;
  logic [15:0]        n_r, n_nxt;
  logic [13:0]        mod_r, mod_nxt;
  logic               ovf_r, ovf_nxt;

  logic               leap;
  logic [4:0]         cur_len;
  logic [4:0]         prev_len;
  logic [4:0]         d_cl;
  logic signed [17:0] add_a, add_b, add_sum;
  logic               wrap;
  logic [13:0]        y_cl;
  logic [3:0]         m_cl;

  // mod_r holds year mod 400 once the reduction pass is over
  always_comb begin
    leap = (mod_r == 14'd0) ||
           ((y_r[1:0] == 2'd0) && (mod_r != CENTURY) && (mod_r != 14'd200) &&
            (mod_r != 14'd300));
    cur_len = month_len(m_r, leap);
    prev_len = (m_r == MONTH_JAN) ? 5'd31 : month_len(m_r - 4'd1, leap);
    if (d_r[4:0] == 5'd0) begin
      d_cl = 5'd1;
    end else if (d_r[4:0] > cur_len) begin
      d_cl = cur_len;
    end else begin
      d_cl = d_r[4:0];
    end
  end

  // one shared adder: day count in the init step, month length in each month step
  always_comb begin
    if (cmd.op == OP_INIT) begin
      add_a = $signed({13'd0, d_cl});
      add_b = sub_r ? -$signed({2'd0, n_r}) : $signed({2'd0, n_r});
    end else begin
      add_a = d_r;
      add_b = sub_r ? $signed({13'd0, prev_len}) : -$signed({13'd0, cur_len});
    end
    add_sum = add_a + add_b;
  end

  always_comb begin
    wrap = sub_r ? (m_r == MONTH_JAN) : (m_r == MONTH_DEC);
    status.mod_ge = (mod_r >= CYCLE_LEN);
    status.step_more = sub_r ? (d_r < 18'sd1) : (d_r > $signed({13'd0, cur_len}));
    status.step_ovf = status.step_more && wrap &&
                      (sub_r ? (y_r == YEAR_MIN) : (y_r == YEAR_MAX));
  end

  always_comb begin
    y_cl = (in_start_year == 14'd0) ? YEAR_MIN :
           (in_start_year > YEAR_MAX) ? YEAR_MAX : in_start_year;
    m_cl = (in_start_month == 4'd0) ? MONTH_JAN :
           (in_start_month > MONTH_DEC) ? MONTH_DEC : in_start_month;
  end

  always_comb begin
    sub_nxt = sub_r;
    y_nxt = y_r;
    m_nxt = m_r;
    d_nxt = d_r;
    n_nxt = n_r;
    mod_nxt = mod_r;
    ovf_nxt = ovf_r;
    case (cmd.op)
      OP_LOAD: begin
        sub_nxt = in_req_type;
        y_nxt = y_cl;
        m_nxt = m_cl;
        d_nxt = $signed({13'd0, in_start_day});
        n_nxt = in_day_count;
        mod_nxt = y_cl;
        ovf_nxt = 1'b0;
      end
      OP_MOD: begin
        mod_nxt = mod_r - CYCLE_LEN;
      end
      OP_INIT: begin
        d_nxt = add_sum;
      end
      OP_STEP: begin
        if (status.step_ovf) begin
          // saturate at the end of the range
          ovf_nxt = 1'b1;
          y_nxt = sub_r ? YEAR_MIN : YEAR_MAX;
          m_nxt = sub_r ? MONTH_JAN : MONTH_DEC;
          d_nxt = sub_r ? 18'sd1 : 18'sd31;
        end else if (status.step_more) begin
          d_nxt = add_sum;
          if (!sub_r) begin
            if (wrap) begin
              m_nxt = MONTH_JAN;
              y_nxt = y_r + 14'd1;
              mod_nxt = (mod_r == CYCLE_LEN - 14'd1) ? 14'd0 : mod_r + 14'd1;
            end else begin
              m_nxt = m_r + 4'd1;
            end
          end else begin
            if (wrap) begin
              m_nxt = MONTH_DEC;
              y_nxt = y_r - 14'd1;
              mod_nxt = (mod_r == 14'd0) ? CYCLE_LEN - 14'd1 : mod_r - 14'd1;
            end else begin
              m_nxt = m_r - 4'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sub_r <= sub_nxt;
    y_r <= y_nxt;
    m_r <= m_nxt;
    d_r <= d_nxt;
    n_r <= n_nxt;
    mod_r <= mod_nxt;
    ovf_r <= ovf_nxt;
  end

  assign out_result_year = y_r;
  assign out_result_month = m_r;
  assign out_result_day = d_r[4:0];
  assign out_year_overflow = ovf_r;

endmodule

// ===== rtl/gdate_ctrl.sv =====
`timescale 1ns / 1ps
module gdate_ctrl import gdate_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  gd_status_t status,
  output gd_cmd_t    cmd,
  output logic       busy,
  output logic       out_valid
);

  gd_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (!status.mod_ge) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (!status.step_more || status.step_ovf) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.op = OP_HOLD;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = OP_LOAD;
      end
      ST_MOD: begin
        if (status.mod_ge) cmd.op = OP_MOD;
      end
      ST_INIT: begin
        cmd.op = OP_INIT;
      end
      ST_STEP: begin
        if (status.step_more) cmd.op = OP_STEP;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer accepted but sequencer not busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_STEP))
    else $error("result strobe without a month step before it");

  a_ovf_only_stepping: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_STEP) |-> (state_r == ST_STEP) && status.step_more)
    else $error("month step issued outside stepping");

endmodule

// ===== rtl/gregorian_date_add_sub_days.sv =====
`timescale 1ns / 1ps
// The year mod 400 is reduced by repeated subtraction, one subtract per cycle (0 to 24 of them,
// start_year / 400); then the months crossed (up to about 2160) are stepped, one month per cycle
// through one adder, before the result strobe.
// A new request is taken only after the result; busy stays high until the strobe is over.
// Result on the out_ ports for one cycle with out_valid; the receiver cannot stall.
// Reset (rst_n, synchronous, active low) clears the sequencer only.
module gregorian_date_add_sub_days import gdate_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic [15:0] in_day_count,
  output logic        out_valid,
  output logic [13:0] out_result_year,
  output logic [3:0]  out_result_month,
  output logic [4:0]  out_result_day,
  output logic        out_year_overflow
);

  gd_cmd_t    cmd;
  gd_status_t status;

  gdate_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  gdate_dp u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_start_year     (in_start_year),
    .in_start_month    (in_start_month),
    .in_start_day      (in_start_day),
    .in_day_count      (in_day_count),
    .status            (status),
    .out_result_year   (out_result_year),
    .out_result_month  (out_result_month),
    .out_result_day    (out_result_day),
    .out_year_overflow (out_year_overflow)
  );

endmodule
